/* rtl/line_reference_rle_decoder_assert.svh */
// Assertion macros shared by the line-reference RLE decoder RTL.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef LINE_REFERENCE_RLE_DECODER_ASSERT_SVH
`define LINE_REFERENCE_RLE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRRLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRRLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lrrle_pkg.sv */
// Package for the line-reference RLE decoder: widths, limits and register codes.
// Used by line_reference_rle_decoder; depends on nothing else.
package lrrle_pkg;

    localparam int MAX_LINE_BYTES = 256;
    localparam int HIST_DEPTH     = 2 * MAX_LINE_BYTES;
    localparam int HIST_AW        = $clog2(HIST_DEPTH);
    localparam int LINE_W         = 9;
    localparam int ROWS_W         = 11;
    localparam int DIST_W         = HIST_AW + 1;
    localparam int POS_W          = 19;
    localparam int RUN_W          = 9;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 11;

    localparam logic [LINE_W-1:0] LINE_MIN       = LINE_W'(4);
    localparam logic [LINE_W-1:0] LINE_MAX       = LINE_W'(MAX_LINE_BYTES);
    localparam logic [LINE_W-1:0] LINE_RESET     = LINE_W'(128);
    localparam logic [ROWS_W-1:0] ROWS_RESET     = ROWS_W'(424);

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = CFG_IDX_W'(1);

    // Stream opcodes.
    localparam logic [7:0] OP_COPY_TWO = 8'h00;
    localparam logic [7:0] OP_COPY_ONE = 8'h01;
    localparam logic [7:0] OP_FILL     = 8'h02;
    localparam logic [7:0] OP_ESCAPE   = 8'h03;

    // Parser phases.
    localparam logic [1:0] PH_OPCODE  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_VALUE   = 2'd2;
    localparam logic [1:0] PH_LITERAL = 2'd3;

endpackage

/* rtl/line_reference_rle_decoder.sv */
// Sequencing: a header byte only updates the parser; each literal or fill byte is written
// in ST_WR, each copy byte is read in ST_RD and then written in ST_WR, and a write that
// completes a group waits while the output register is stalled. The copy rate is set by
// the registered read port of the two-line history memory, one byte per read/write pair.
// Input stalls in the cycle after a configuration write while the image size settles.
// Reset (rst_n, async) clears control state; the history memory needs no clearing pass.
module line_reference_rle_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          in_byte,
    input  logic                                start_req,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          byte_a,
    output logic [7:0]                          byte_b,
    output logic [7:0]                          byte_c,
    output logic [7:0]                          byte_d,
    output logic [2:0]                          byte_count,
    output logic                                run_last,
    output logic                                image_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrrle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrrle_pkg::CFG_DATA_W-1:0]    cfg_data
);

    `include "line_reference_rle_decoder_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    // Configuration and derived image geometry.
    logic [lrrle_pkg::LINE_W-1:0]   line_reg;
    logic [lrrle_pkg::ROWS_W-1:0]   rows_reg;
    logic [lrrle_pkg::LINE_W-1:0]   eff_line_reg;
    logic [lrrle_pkg::POS_W-1:0]    total_reg;
    logic                           settle_reg;
    logic [lrrle_pkg::LINE_W-1:0]   eff_line;
    logic [lrrle_pkg::ROWS_W-1:0]   eff_rows;
    logic [lrrle_pkg::LINE_W+lrrle_pkg::ROWS_W-1:0] total_prod;

    // Parser and position.
    logic [1:0]                     state_reg, state_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [1:0]                     pop_reg, pop_next;
    logic [lrrle_pkg::RUN_W-1:0]    plen_reg, plen_next;
    logic [lrrle_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                           finished_reg, finished_next;

    // Run sequencer.
    logic [lrrle_pkg::RUN_W-1:0]    rem_reg, rem_next;
    logic                           copy_reg, copy_next;
    logic [lrrle_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic [7:0]                     fill_reg, fill_next;
    logic [1:0]                     slot_reg, slot_next;
    logic [7:0]                     pk_reg [0:3];
    logic                           zero_reg;

    // History memory.
    logic [7:0]                     hist_mem [0:lrrle_pkg::HIST_DEPTH-1];
    logic [7:0]                     rd_data_reg;
    logic [lrrle_pkg::HIST_AW-1:0]  rd_addr;
    logic                           hist_we;
    logic [7:0]                     wr_val;

    // Output register.
    logic                           out_valid_reg;
    logic [7:0]                     out_byte_reg [0:3];
    logic [2:0]                     out_count_reg;
    logic                           out_last_reg;
    logic                           out_done_reg;
    logic                           out_load;
    logic [7:0]                     out_byte_next [0:3];

    // Accept-cycle decode.
    logic                           in_take;
    logic                           grp_done;
    logic                           out_free;
    logic                           advance;
    logic [lrrle_pkg::POS_W-1:0]    pos_eff;
    logic                           fin_eff;
    logic                           go;
    logic [lrrle_pkg::RUN_W-1:0]    n_raw;
    logic [lrrle_pkg::POS_W-1:0]    room;
    logic [lrrle_pkg::POS_W-1:0]    pos_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || settle_reg;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        eff_line = line_reg;
        if (line_reg < lrrle_pkg::LINE_MIN)
        begin
            eff_line = lrrle_pkg::LINE_MIN;
        end
        else if (line_reg > lrrle_pkg::LINE_MAX)
        begin
            eff_line = lrrle_pkg::LINE_MAX;
        end
        eff_rows = (rows_reg == '0) ? lrrle_pkg::ROWS_W'(1) : rows_reg;
        total_prod = (lrrle_pkg::LINE_W+lrrle_pkg::ROWS_W)'(eff_rows) *
                     (lrrle_pkg::LINE_W+lrrle_pkg::ROWS_W)'(eff_line);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg     <= lrrle_pkg::LINE_RESET;
            rows_reg     <= lrrle_pkg::ROWS_RESET;
            eff_line_reg <= lrrle_pkg::LINE_RESET;
            total_reg    <= lrrle_pkg::POS_W'(424 * 128);
            settle_reg   <= 1'b0;
        end
        else
        begin
            settle_reg   <= cfg_valid && cfg_ready;
            eff_line_reg <= eff_line;
            total_reg    <= total_prod[lrrle_pkg::POS_W-1:0];
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lrrle_pkg::CFG_LINE_BYTES: line_reg <= cfg_data[lrrle_pkg::LINE_W-1:0];
                    lrrle_pkg::CFG_IMAGE_ROWS: rows_reg <= cfg_data[lrrle_pkg::ROWS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // History read address; positions ahead of the image start read as zero.
    assign rd_addr  = pos_reg[lrrle_pkg::HIST_AW-1:0] - dist_reg[lrrle_pkg::HIST_AW-1:0];
    assign wr_val   = copy_reg ? (zero_reg ? 8'h00 : rd_data_reg) : fill_reg;
    assign grp_done = (slot_reg == 2'd3) || (rem_reg == lrrle_pkg::RUN_W'(1));
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = !grp_done || out_free;
    assign hist_we  = (state_reg == ST_WR) && advance;
    assign out_load = hist_we && grp_done;
    assign pos_inc  = pos_reg + lrrle_pkg::POS_W'(1);

    always_ff @(posedge clk)
    begin
        rd_data_reg <= hist_mem[rd_addr];
        zero_reg    <= pos_reg < lrrle_pkg::POS_W'(dist_reg);
        if (hist_we)
        begin
            hist_mem[pos_reg[lrrle_pkg::HIST_AW-1:0]] <= wr_val;
            pk_reg[slot_reg] <= wr_val;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pop_next      = pop_reg;
        plen_next     = plen_reg;
        pos_next      = pos_reg;
        finished_next = finished_reg;
        rem_next      = rem_reg;
        copy_next     = copy_reg;
        dist_next     = dist_reg;
        fill_next     = fill_reg;
        slot_next     = slot_reg;
        pos_eff       = pos_reg;
        fin_eff       = finished_reg;
        go            = 1'b0;
        n_raw         = lrrle_pkg::RUN_W'(1);
        room          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (start_req)
                    begin
                        pos_eff    = '0;
                        fin_eff    = 1'b0;
                        phase_next = lrrle_pkg::PH_OPCODE;
                        pop_next   = 2'd0;
                        plen_next  = '0;
                    end
                    if (pos_eff >= total_reg)
                    begin
                        fin_eff = 1'b1;
                    end
                    pos_next      = pos_eff;
                    finished_next = fin_eff;
                    if (!fin_eff)
                    begin
                        case (phase_next)
                            lrrle_pkg::PH_OPCODE:
                            begin
                                if (in_byte inside {lrrle_pkg::OP_COPY_TWO,
                                                    lrrle_pkg::OP_COPY_ONE,
                                                    lrrle_pkg::OP_FILL})
                                begin
                                    pop_next   = in_byte[1:0];
                                    phase_next = lrrle_pkg::PH_LENGTH;
                                end
                                else if (in_byte == lrrle_pkg::OP_ESCAPE)
                                begin
                                    phase_next = lrrle_pkg::PH_LITERAL;
                                end
                                else
                                begin
                                    go        = 1'b1;
                                    copy_next = 1'b0;
                                    fill_next = in_byte;
                                end
                            end
                            lrrle_pkg::PH_LENGTH:
                            begin
                                plen_next = {1'b0, in_byte} + lrrle_pkg::RUN_W'(1);
                                if (pop_next == lrrle_pkg::OP_FILL[1:0])
                                begin
                                    phase_next = lrrle_pkg::PH_VALUE;
                                end
                                else
                                begin
                                    go         = 1'b1;
                                    copy_next  = 1'b1;
                                    n_raw      = plen_next;
                                    phase_next = lrrle_pkg::PH_OPCODE;
                                    if (pop_next == lrrle_pkg::OP_COPY_TWO[1:0])
                                    begin
                                        dist_next = {eff_line_reg, 1'b0};
                                    end
                                    else
                                    begin
                                        dist_next = {1'b0, eff_line_reg};
                                    end
                                end
                            end
                            lrrle_pkg::PH_VALUE:
                            begin
                                go         = 1'b1;
                                copy_next  = 1'b0;
                                fill_next  = in_byte;
                                n_raw      = plen_next;
                                phase_next = lrrle_pkg::PH_OPCODE;
                            end
                            default:
                            begin
                                go         = 1'b1;
                                copy_next  = 1'b0;
                                fill_next  = in_byte;
                                phase_next = lrrle_pkg::PH_OPCODE;
                            end
                        endcase
                        if (go)
                        begin
                            room      = total_reg - pos_eff;
                            rem_next  = (room < lrrle_pkg::POS_W'(n_raw)) ?
                                        room[lrrle_pkg::RUN_W-1:0] : n_raw;
                            slot_next = 2'd0;
                            state_next = copy_next ? ST_RD : ST_WR;
                        end
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (advance)
                begin
                    pos_next  = pos_inc;
                    rem_next  = rem_reg - lrrle_pkg::RUN_W'(1);
                    slot_next = grp_done ? 2'd0 : slot_reg + 2'd1;
                    if (rem_reg == lrrle_pkg::RUN_W'(1))
                    begin
                        state_next = ST_IDLE;
                        if (pos_inc >= total_reg)
                        begin
                            finished_next = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = copy_reg ? ST_RD : ST_WR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= lrrle_pkg::PH_OPCODE;
            pop_reg      <= 2'd0;
            plen_reg     <= '0;
            pos_reg      <= '0;
            finished_reg <= 1'b0;
            rem_reg      <= '0;
            copy_reg     <= 1'b0;
            dist_reg     <= '0;
            fill_reg     <= 8'h00;
            slot_reg     <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            pop_reg      <= pop_next;
            plen_reg     <= plen_next;
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
            rem_reg      <= rem_next;
            copy_reg     <= copy_next;
            dist_reg     <= dist_next;
            fill_reg     <= fill_next;
            slot_reg     <= slot_next;
        end
    end

    // Bytes packed so far, the byte written this cycle, zeros beyond the count.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (2'(i) < slot_reg)
            begin
                out_byte_next[i] = pk_reg[i];
            end
            else if (2'(i) == slot_reg)
            begin
                out_byte_next[i] = wr_val;
            end
            else
            begin
                out_byte_next[i] = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                out_byte_reg[i] <= out_byte_next[i];
            end
            out_count_reg <= {1'b0, slot_reg} + 3'd1;
            out_last_reg  <= (rem_reg == lrrle_pkg::RUN_W'(1));
            out_done_reg  <= (rem_reg == lrrle_pkg::RUN_W'(1)) && (pos_inc >= total_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_a     = out_byte_reg[0];
    assign byte_b     = out_byte_reg[1];
    assign byte_c     = out_byte_reg[2];
    assign byte_d     = out_byte_reg[3];
    assign byte_count = out_count_reg;
    assign run_last   = out_last_reg;
    assign image_done = out_done_reg;

    `LRRLE_ASSERT_SAME(a_out_from_write, $rose(out_valid_reg), $past(state_reg) == ST_WR, "result appeared without a history write")
    `LRRLE_ASSERT_SAME(a_count_range, out_valid_reg, (out_count_reg != 3'd0) && (out_count_reg <= 3'd4), "result byte count out of range")
    `LRRLE_ASSERT_NEXT(a_finished_quiet, in_take && finished_reg && !start_req, state_reg == ST_IDLE, "finished image started a run")
    `LRRLE_ASSERT_SAME(a_run_nonempty, (state_reg == ST_RD) || (state_reg == ST_WR), rem_reg != '0, "run sequencer active with no bytes left")

endmodule
